// ===== rtl/tcw_pkg.sv =====
// Shared types, constants and register indexes of the text console writer.
package tcw_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam int CHAR_W   = 8;
   localparam int COLOUR_W = 8;
   localparam int ADDR_W   = 11;
   localparam int POS_W    = 11;
   localparam int TAB_W    = 4;
   localparam int CELL_W   = CHAR_W + COLOUR_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_TAB_CELLS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLANK_COLOUR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ERASE_COLOUR = 2'd2;

   localparam logic [TAB_W-1:0]    TAB_CELLS_RST    = 4'd2;
   localparam logic [COLOUR_W-1:0] BLANK_COLOUR_RST = 8'd0;
   localparam logic [COLOUR_W-1:0] ERASE_COLOUR_RST = 8'd7;

   localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [CHAR_W-1:0]   char_code;
      logic [COLOUR_W-1:0] colour;
      logic [ADDR_W-1:0]   cell_address;
      logic              end_of_string;
   } tcw_req_type;

   typedef struct packed {
      logic [POS_W-1:0]    cursor_position;
      logic              beep;
      logic [CHAR_W-1:0]   cell_char;
      logic [COLOUR_W-1:0] cell_colour;
      logic              cursor_update;
   } tcw_rsp_type;

endpackage

// ===== rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
   parameter int WIDTH = tcw_pkg::CELL_W,
   parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/text_console_writer.sv =====
// Text console writer top level: cursor sequencer, screen store and result register.
//
// A COLUMNS x ROWS store of character/colour cells with a write cursor. After
// reset a clearing pass zeroes the store, during which req_stall stays high
// (configuration writes are taken throughout). One word is handled at a time
// by a small sequencer around a single saturating cursor adder: a read or an
// ordinary write passes through its read or execute state to the completion
// state, which loads the result register; a tab takes one cursor step per
// cycle for up to tab_cells steps, ending early at the past-end position; and a
// write at the past-end position first scrolls, copying the store through the
// one RAM read port and one write port at one cell per cycle, then blanks the
// last row. The next word is accepted while a result still waits on rsp_stall;
// a second finished word holds in its completion state until that result leaves.
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tcw_pkg::tcw_req_type                req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tcw_pkg::tcw_rsp_type                rsp_payload,
   input  logic                                csr_we,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int CW     = $clog2(CELLS + 1);
   localparam int AW     = $clog2(CELLS);
   localparam int COLW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int POS_W  = tcw_pkg::POS_W;
   localparam int ADDR_W = tcw_pkg::ADDR_W;
   localparam int CMPW   = (CW > ADDR_W) ? CW : ADDR_W;
   localparam int TAB_W  = tcw_pkg::TAB_W;
   localparam int CELL_W = tcw_pkg::CELL_W;

   localparam logic [CW-1:0]   CELLS_C    = CW'(CELLS);
   localparam logic [CW-1:0]   COLS_C     = CW'(COLUMNS);
   localparam logic [CW-1:0]   LAST_ROW_C = CW'(CELLS - COLUMNS);
   localparam logic [CW-1:0]   LAST_C     = CW'(CELLS - 1);
   localparam logic [COLW-1:0] LAST_COL_C = COLW'(COLUMNS - 1);
   localparam logic [CMPW-1:0] CELLS_CMP  = CMPW'(CELLS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_TAB   = 3'd4;
   localparam logic [2:0] ST_COPY  = 3'd5;
   localparam logic [2:0] ST_BLANK = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]                     state_ff, state_in;
   logic [CW-1:0]                  cursor_ff, cursor_in;
   logic [COLW-1:0]                col_ff, col_in;
   logic [CW-1:0]                  addr_ff, addr_in;
   logic                           copy_vld_ff, copy_vld_in;
   logic [AW-1:0]                  copy_dst_ff, copy_dst_in;
   logic [TAB_W-1:0]               cnt_ff, cnt_in;
   tcw_pkg::tcw_req_type           item_ff, item_in;
   logic                           beep_ff, beep_in;
   logic [CELL_W-1:0]              cell_ff, cell_in;
   logic [TAB_W-1:0]               tab_ff, tab_in;
   logic [tcw_pkg::COLOUR_W-1:0]   blank_ff, blank_in;
   logic [tcw_pkg::COLOUR_W-1:0]   erase_ff, erase_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   tcw_pkg::tcw_rsp_type           rsp_ff, rsp_in;

   logic                           op_sub;
   logic [CW-1:0]                  op_b;
   logic [CW:0]                    sum;
   logic [CW-1:0]                  sum_sat;
   logic [COLW-1:0]                col_inc;
   logic [COLW-1:0]                col_dec;
   logic [CW-1:0]                  copy_dst_full;

   logic                           ram_wr_en;
   logic [AW-1:0]                  ram_wr_addr;
   logic [CELL_W-1:0]              ram_wr_data;
   logic [AW-1:0]                  ram_rd_addr;
   logic [CELL_W-1:0]              ram_rd_data;

   logic                           req_take;
   logic                           rsp_take;

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign rsp_take    = rsp_valid_ff && !rsp_stall;

   // shared saturating cursor adder
   always_comb begin
      op_sub = 1'b0;
      op_b   = CW'(1);
      if (state_ff == ST_EXEC) begin
         case (item_ff.char_code)
            tcw_pkg::CH_NL: begin
               op_b = COLS_C - CW'(col_ff);
            end
            tcw_pkg::CH_BS: begin
               op_sub = 1'b1;
            end
            tcw_pkg::CH_CR: begin
               op_sub = 1'b1;
               op_b   = CW'(col_ff);
            end
            tcw_pkg::CH_VT: begin
               op_b = COLS_C;
            end
            default: begin
               op_b = CW'(1);
            end
         endcase
      end
      sum     = op_sub ? ({1'b0, cursor_ff} - {1'b0, op_b})
                       : ({1'b0, cursor_ff} + {1'b0, op_b});
      sum_sat = (sum > {1'b0, CELLS_C}) ? CELLS_C : sum[CW-1:0];
   end

   assign col_inc       = (col_ff == LAST_COL_C) ? '0 : col_ff + COLW'(1);
   assign col_dec       = (col_ff == '0) ? LAST_COL_C : col_ff - COLW'(1);
   assign copy_dst_full = addr_ff - COLS_C;

   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      col_in       = col_ff;
      addr_in      = addr_ff;
      copy_vld_in  = copy_vld_ff;
      copy_dst_in  = copy_dst_ff;
      cnt_in       = cnt_ff;
      item_in      = item_ff;
      beep_in      = beep_ff;
      cell_in      = cell_ff;
      tab_in       = tab_ff;
      blank_in     = blank_ff;
      erase_in     = erase_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cursor_ff[AW-1:0];
      ram_wr_data  = {item_ff.colour, item_ff.char_code};
      ram_rd_addr  = AW'(req_payload.cell_address);

      if (csr_we) begin
         case (csr_index)
            tcw_pkg::REG_TAB_CELLS:    tab_in   = csr_wdata[TAB_W-1:0];
            tcw_pkg::REG_BLANK_COLOUR: blank_in = csr_wdata;
            tcw_pkg::REG_ERASE_COLOUR: erase_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_ff[AW-1:0];
            ram_wr_data = '0;
            if (addr_ff == LAST_C) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + CW'(1);
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               item_in = req_payload;
               beep_in = 1'b0;
               cell_in = '0;
               state_in = (req_payload.mode == tcw_pkg::MODE_READ) ? ST_READ : ST_EXEC;
            end
         end
         ST_READ: begin
            if (CMPW'(item_ff.cell_address) < CELLS_CMP) begin
               cell_in = ram_rd_data;
            end
            state_in = ST_DONE;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (item_ff.char_code)
               tcw_pkg::CH_NL, tcw_pkg::CH_CR: begin
                  cursor_in = sum_sat;
                  col_in    = '0;
               end
               tcw_pkg::CH_TAB: begin
                  cnt_in   = tab_ff;
                  state_in = ST_TAB;
               end
               tcw_pkg::CH_BS: begin
                  if (cursor_ff != '0) begin
                     cursor_in   = sum_sat;
                     col_in      = col_dec;
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = sum_sat[AW-1:0];
                     ram_wr_data = {erase_ff, tcw_pkg::CH_SPACE};
                  end
               end
               tcw_pkg::CH_BEL: begin
                  beep_in = 1'b1;
               end
               tcw_pkg::CH_VT: begin
                  cursor_in = sum_sat;
                  if (sum_sat == CELLS_C) begin
                     col_in = '0;
                  end
               end
               default: begin
                  if (cursor_ff == CELLS_C) begin
                     addr_in     = COLS_C;
                     copy_vld_in = 1'b0;
                     state_in    = ST_COPY;
                  end else begin
                     ram_wr_en = 1'b1;
                     cursor_in = sum_sat;
                     col_in    = col_inc;
                  end
               end
            endcase
         end
         ST_TAB: begin
            if (cnt_ff == '0 || cursor_ff == CELLS_C) begin
               state_in = ST_DONE;
            end else begin
               cursor_in = sum_sat;
               col_in    = col_inc;
               cnt_in    = cnt_ff - TAB_W'(1);
            end
         end
         ST_COPY: begin
            ram_rd_addr = addr_ff[AW-1:0];
            if (copy_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = copy_dst_ff;
               ram_wr_data = ram_rd_data;
            end
            if (addr_ff == CELLS_C) begin
               copy_vld_in = 1'b0;
               addr_in     = LAST_ROW_C;
               state_in    = ST_BLANK;
            end else begin
               copy_vld_in = 1'b1;
               copy_dst_in = copy_dst_full[AW-1:0];
               addr_in     = addr_ff + CW'(1);
            end
         end
         ST_BLANK: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_ff[AW-1:0];
            ram_wr_data = {blank_ff, tcw_pkg::CH_SPACE};
            if (addr_ff == LAST_C) begin
               cursor_in = LAST_ROW_C;
               col_in    = '0;
               state_in  = ST_EXEC;
            end else begin
               addr_in = addr_ff + CW'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.cursor_position = POS_W'(cursor_ff);
               rsp_in.beep            = beep_ff;
               rsp_in.cell_char       = cell_ff[tcw_pkg::CHAR_W-1:0];
               rsp_in.cell_colour     = cell_ff[CELL_W-1:tcw_pkg::CHAR_W];
               rsp_in.cursor_update   = (item_ff.mode == tcw_pkg::MODE_WRITE) &&
                                        item_ff.end_of_string;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cursor_ff    <= '0;
         col_ff       <= '0;
         addr_ff      <= '0;
         copy_vld_ff  <= 1'b0;
         tab_ff       <= tcw_pkg::TAB_CELLS_RST;
         blank_ff     <= tcw_pkg::BLANK_COLOUR_RST;
         erase_ff     <= tcw_pkg::ERASE_COLOUR_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         addr_ff      <= addr_in;
         copy_vld_ff  <= copy_vld_in;
         tab_ff       <= tab_in;
         blank_ff     <= blank_in;
         erase_ff     <= erase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_dst_ff <= copy_dst_in;
      cnt_ff      <= cnt_in;
      item_ff     <= item_in;
      beep_ff     <= beep_in;
      cell_ff     <= cell_in;
      rsp_ff      <= rsp_in;
   end

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CELLS_C)
      else $error("cursor beyond past-end position");

   a_col_tracks_cursor: assert property (@(posedge clock) disable iff (reset)
      (cursor_ff == CELLS_C) |-> (col_ff == '0))
      else $error("column not zero at past-end position");

   a_scroll_lands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLANK && addr_ff == LAST_C) |=> (cursor_ff == LAST_ROW_C))
      else $error("scroll did not leave cursor at last row start");

   a_rsp_only_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside completion");

endmodule

// ===== sim/tcw_checker.sv =====
`timescale 1ns / 100ps
// Checker of the text console writer: tracks screen and cursor, predicts and compares words.
module tcw_checker #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  tcw_pkg::tcw_req_type            req_payload,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  tcw_pkg::tcw_rsp_type            rsp_payload,
   input  logic                            csr_we,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatch_count,
   output int                              words_outstanding,
   output int                              cursor_now
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   logic [CELL_W-1:0]   screen [CELLS];
   int                  cursor;
   logic [TAB_W-1:0]    tab_cells;
   logic [COLOUR_W-1:0] blank_colour;
   logic [COLOUR_W-1:0] erase_colour;
   tcw_rsp_type         expected_q [$];

   function automatic int clamp_cursor(int p);
      return (p > CELLS) ? CELLS : p;
   endfunction

   function automatic tcw_rsp_type apply_word(tcw_req_type w);
      tcw_rsp_type r;
      r = '0;
      if (w.mode == MODE_READ) begin
         if (w.cell_address < CELLS) begin
            r.cell_char   = screen[w.cell_address][CHAR_W-1:0];
            r.cell_colour = screen[w.cell_address][CELL_W-1:CHAR_W];
         end
      end else begin
         case (w.char_code)
            CH_NL:  cursor = clamp_cursor(cursor + COLUMNS - cursor % COLUMNS);
            CH_TAB: cursor = clamp_cursor(cursor + tab_cells);
            CH_BS: begin
               if (cursor > 0) begin
                  cursor = cursor - 1;
                  screen[cursor] = {erase_colour, CH_SPACE};
               end
            end
            CH_BEL: r.beep = 1'b1;
            CH_CR:  cursor = cursor - cursor % COLUMNS;
            CH_VT:  cursor = clamp_cursor(cursor + COLUMNS);
            default: begin
               if (cursor >= CELLS) begin
                  for (int i = COLUMNS; i < CELLS; i++) screen[i - COLUMNS] = screen[i];
                  for (int i = CELLS - COLUMNS; i < CELLS; i++)
                     screen[i] = {blank_colour, CH_SPACE};
                  cursor = CELLS - COLUMNS;
               end
               screen[cursor] = {w.colour, w.char_code};
               cursor = clamp_cursor(cursor + 1);
            end
         endcase
         r.cursor_update = w.end_of_string;
      end
      r.cursor_position = cursor[POS_W-1:0];
      return r;
   endfunction

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : track
      tcw_rsp_type got;
      tcw_rsp_type want;
      if (reset) begin
         foreach (screen[i]) screen[i] = '0;
         cursor         = 0;
         tab_cells      = TAB_CELLS_RST;
         blank_colour   = BLANK_COLOUR_RST;
         erase_colour   = ERASE_COLOUR_RST;
         mismatch_count = 0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_TAB_CELLS:    tab_cells    = csr_wdata[TAB_W-1:0];
               REG_BLANK_COLOUR: blank_colour = csr_wdata;
               REG_ERASE_COLOUR: erase_colour = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (expected_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: result word with none expected, actual %h", $time, got);
            end else begin
               want = expected_q.pop_front();
               report_field("cursor_position", int'(want.cursor_position),
                            int'(got.cursor_position));
               report_field("beep", int'(want.beep), int'(got.beep));
               report_field("cell_char", int'(want.cell_char), int'(got.cell_char));
               report_field("cell_colour", int'(want.cell_colour), int'(got.cell_colour));
               report_field("cursor_update", int'(want.cursor_update),
                            int'(got.cursor_update));
            end
         end
         if (req_valid && !req_stall) expected_q.push_back(apply_word(req_payload));
      end
      words_outstanding = expected_q.size();
      cursor_now        = cursor;
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top of the text console writer: clock, reset, stimulus, flow control and verdict.
module tb_top;
   import tcw_pkg::*;

   localparam int COLUMNS = COLUMNS_DEF;
   localparam int ROWS    = ROWS_DEF;
   localparam int CELLS   = COLUMNS * ROWS;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   tcw_req_type            req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   tcw_rsp_type            rsp_payload;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatch_count;
   int words_outstanding;
   int cursor_now;
   bit quiet;
   bit hold_request;
   int scrolls_left;

   text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   tcw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) console_model (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload       (rsp_payload),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .words_outstanding (words_outstanding),
      .cursor_now        (cursor_now)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic bit is_control(logic [CHAR_W-1:0] c);
      return c inside {CH_BEL, CH_BS, CH_TAB, CH_NL, CH_VT, CH_CR};
   endfunction

   function automatic logic [CHAR_W-1:0] printable_char();
      logic [CHAR_W-1:0] c;
      do c = CHAR_W'($urandom_range(0, 255)); while (is_control(c));
      return c;
   endfunction

   function automatic tcw_req_type write_word(logic [CHAR_W-1:0] ch,
                                              logic [COLOUR_W-1:0] colour, logic eos);
      tcw_req_type w;
      w.mode          = MODE_WRITE;
      w.char_code     = ch;
      w.colour        = colour;
      w.cell_address  = ADDR_W'($urandom_range(0, 2047));
      w.end_of_string = eos;
      return w;
   endfunction

   function automatic tcw_req_type read_word(logic [ADDR_W-1:0] addr);
      tcw_req_type w;
      w.mode          = MODE_READ;
      w.char_code     = CHAR_W'($urandom_range(0, 255));
      w.colour        = COLOUR_W'($urandom_range(0, 255));
      w.cell_address  = addr;
      w.end_of_string = 1'($urandom_range(0, 1));
      return w;
   endfunction

   task automatic send_word(input tcw_req_type w);
      int gap;
      req_payload <= w;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // a write at the past-end position costs a full copy of the store: ration them
   task automatic send_write(input logic [CHAR_W-1:0] ch, input logic [COLOUR_W-1:0] colour,
                             input logic eos);
      logic [CHAR_W-1:0] c;
      c = ch;
      if (!is_control(c) && cursor_now >= CELLS) begin
         if (scrolls_left == 0) c = CH_BS;
         else scrolls_left--;
      end
      send_word(write_word(c, colour, eos));
   endtask

   task automatic send_read();
      int off;
      int addr;
      if ($urandom_range(0, 1)) begin
         off  = $urandom_range(0, 2 * COLUMNS - 1);
         addr = cursor_now - 1 - off;
         if (addr < 0) addr = 0;
      end else begin
         addr = $urandom_range(0, 2047);
      end
      send_word(read_word(ADDR_W'(addr)));
   endtask

   task automatic send_noise();
      logic [CHAR_W-1:0] c;
      case ($urandom_range(0, 7))
         0: c = CH_BEL;
         1: c = CH_BS;
         2: c = CH_TAB;
         3: c = CH_NL;
         4: c = CH_CR;
         5: c = CH_VT;
         default: c = CHAR_W'($urandom_range(0, 255));
      endcase
      send_write(c, COLOUR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic run_random(input int count);
      int sent;
      int len;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            len = $urandom_range(1, 16);
            for (int k = 0; k < len; k++)
               send_write(printable_char(), COLOUR_W'($urandom_range(0, 255)), k == len - 1);
            sent += len;
            if ($urandom_range(0, 1)) begin
               send_write(($urandom_range(0, 9) < 3) ? CH_NL : CH_CR,
                          COLOUR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               sent++;
            end
         end else if (pick < 75) begin
            send_noise();
            sent++;
         end else begin
            send_read();
            sent++;
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (words_outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   initial begin : receiver
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            burst = $urandom_range(1, 15);
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat (burst - 1) @(negedge clock);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      csr_we       = 1'b0;
      csr_index    = REG_TAB_CELLS;
      csr_wdata    = '0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      scrolls_left = 30;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // cleared store, then every control code near the top left corner
      send_word(read_word(0));
      send_word(read_word(11'h7FF));
      send_write(8'h41, 8'hFF, 1'b1);
      send_write(8'hFF, 8'h00, 1'b0);
      send_write(8'h00, 8'h5A, 1'b0);
      send_write(CH_BEL, 8'h00, 1'b1);
      send_write(CH_TAB, 8'h00, 1'b0);
      send_write(CH_CR, 8'h00, 1'b0);
      send_write(CH_BS, 8'h00, 1'b0);
      send_write(CH_VT, 8'h00, 1'b0);
      send_write(CH_BS, 8'h00, 1'b1);
      send_word(read_word(ADDR_W'(COLUMNS - 1)));
      send_write(CH_NL, 8'h00, 1'b0);
      // walk down past the end, then saturate and scroll
      repeat (ROWS) send_write(CH_VT, 8'h00, 1'b0);
      send_write(CH_TAB, 8'h00, 1'b0);
      send_write(CH_NL, 8'h00, 1'b0);
      send_write(CH_CR, 8'h00, 1'b0);
      send_write(CH_BS, 8'h00, 1'b0);
      send_write(8'h5A, 8'h81, 1'b0);
      send_write(8'h7E, 8'h3C, 1'b1);
      send_word(read_word(ADDR_W'(CELLS - COLUMNS)));
      send_word(read_word(ADDR_W'(CELLS - 1)));
      send_word(read_word(ADDR_W'(CELLS)));
      run_random(165);

      wait_idle();
      write_reg(REG_TAB_CELLS, 8'd0);
      write_reg(REG_BLANK_COLOUR, 8'hFF);
      write_reg(REG_ERASE_COLOUR, 8'h00);
      scrolls_left = 30;
      hold_request = 1'b1;
      run_random(165);

      wait_idle();
      write_reg(REG_TAB_CELLS, 8'd15);
      write_reg(REG_BLANK_COLOUR, 8'h00);
      write_reg(REG_ERASE_COLOUR, 8'hFF);
      scrolls_left = 30;
      run_random(165);

      wait_idle();
      write_reg(REG_TAB_CELLS, CSR_DATA_W'($urandom_range(1, 14)));
      write_reg(REG_BLANK_COLOUR, CSR_DATA_W'($urandom_range(0, 255)));
      write_reg(REG_ERASE_COLOUR, CSR_DATA_W'($urandom_range(0, 255)));
      scrolls_left = 30;
      quiet = 1'b1;
      run_random(165);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
